// ===== rtl/core/oct_pkg.sv =====
// Shared types and constants for the one-shot compare timer.
// No dependencies; every module of the block imports this package.
package oct_pkg;

  localparam int NUM_CHANNELS  = 3;
  localparam int COUNT_BITS    = 16;
  localparam int WRAP_BITS     = 16;
  localparam int DIV_BITS      = 7;
  localparam int PRESCALE_BITS = 6;
  localparam int CMD_BITS      = 3;
  localparam int CHAN_BITS     = 2;
  localparam int MASK_BITS     = NUM_CHANNELS + 1;
  localparam int STOP_CHANNEL  = 3;

  localparam logic [DIV_BITS-1:0] DIVIDE_MAX   = DIV_BITS'(64);
  localparam logic [DIV_BITS-1:0] DIVIDE_MIN   = DIV_BITS'(1);
  localparam logic [DIV_BITS-1:0] DIVIDE_RESET = DIVIDE_MAX;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ARM     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_RESTART = 3'd4
  } oct_cmd_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [CHAN_BITS-1:0]  channel;
    logic [COUNT_BITS-1:0] delay_ticks;
    logic [MASK_BITS-1:0]  clear_mask;
  } oct_cmd_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]                   counter;
    logic [PRESCALE_BITS-1:0]                prescale;
    logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] compare;
    logic [NUM_CHANNELS-1:0]                 armed;
    logic [MASK_BITS-1:0]                    events;
    logic [WRAP_BITS-1:0]                    wraps;
    logic                                    stop;
  } oct_state_t;

endpackage

// ===== rtl/core/oct_step.sv =====
// Next-state logic of the timer for one command word.
// Depends on oct_pkg for the command and state types.
module oct_step import oct_pkg::*; (
  input  oct_state_t          state_i,
  input  oct_cmd_t            cmd_i,
  input  logic [DIV_BITS-1:0] divide_i,
  output oct_state_t          state_o,
  output logic                wake_o
);

  logic [DIV_BITS-1:0]     divide_eff;
  logic [DIV_BITS-1:0]     prescale_inc;
  logic [COUNT_BITS-1:0]   counter_inc;
  logic [COUNT_BITS-1:0]   arm_value;
  logic                    wrap;
  logic [NUM_CHANNELS-1:0] match;
  logic                    chan_ok;

  always_comb begin
    if (divide_i < DIVIDE_MIN) begin
      divide_eff = DIVIDE_MIN;
    end else if (divide_i > DIVIDE_MAX) begin
      divide_eff = DIVIDE_MAX;
    end else begin
      divide_eff = divide_i;
    end
  end

  assign prescale_inc = {1'b0, state_i.prescale} + DIV_BITS'(1);
  assign counter_inc  = state_i.counter + COUNT_BITS'(1);
  assign wrap         = (counter_inc == '0);
  assign arm_value    = state_i.counter + cmd_i.delay_ticks;
  assign chan_ok      = (cmd_i.channel != '0) &&
                        ({1'b0, cmd_i.channel} <= (CHAN_BITS + 1)'(NUM_CHANNELS));

  // Compare against the counter value after the increment.
  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      match[k] = state_i.armed[k] && (state_i.compare[k] == counter_inc);
    end
  end

  always_comb begin
    state_o = state_i;
    wake_o  = 1'b0;
    unique case (oct_cmd_e'(cmd_i.command))
      CMD_TICK: begin
        if (prescale_inc >= divide_eff) begin
          state_o.prescale = '0;
          state_o.counter  = counter_inc;
          if (wrap) begin
            state_o.wraps                 = state_i.wraps + WRAP_BITS'(1);
            state_o.events[NUM_CHANNELS]  = 1'b1;
          end
          state_o.armed = state_i.armed & ~match;
          state_o.events[NUM_CHANNELS-1:0] = state_i.events[NUM_CHANNELS-1:0] | match;
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (k == STOP_CHANNEL - 1 && match[k]) begin
              state_o.stop = 1'b1;
            end
          end
          wake_o = wrap || (match != '0);
        end else begin
          state_o.prescale = prescale_inc[PRESCALE_BITS-1:0];
        end
      end
      CMD_ARM: begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          if (chan_ok && ({1'b0, cmd_i.channel} == (CHAN_BITS + 1)'(k + 1))) begin
            state_o.compare[k] = arm_value;
            state_o.armed[k]   = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        state_o.events = state_i.events & ~cmd_i.clear_mask;
      end
      CMD_RELEASE: begin
        state_o.stop = 1'b0;
      end
      CMD_RESTART: begin
        state_o.counter  = '0;
        state_o.prescale = '0;
        state_o.wraps    = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== rtl/core/oneshot_compare_timer.sv =====
// Top level of the one-shot compare timer: input register, state and result register.
// Depends on oct_pkg and on oct_step for the per-word state update.
//
// Usage:
//   Command words enter on the in_ channel (valid/ready). Each accepted word
//   yields exactly one result word on the out_ channel, in order.
//   A tick command feeds one clock into the prescaler; the counter advances
//   once every prescale_divide ticks. Arm, clear, release and restart act on
//   the channel, event and counter state as their names say.
//   The prescale divide is written over the cfg_ channel, which is always
//   ready; write it only while no word is in flight.
//   From acceptance, a word waits in the input register, then the state
//   update loads the result register. Throughput is one word per cycle
//   while the receiver keeps up; the state update is combinational.
//   When the receiver stalls, the result word holds and the input register
//   still takes one more word; after that in_ready_o drops until the result
//   is taken.
//   Reset clears the counter, prescaler, channels, events and flags, sets the
//   divide to 64 and empties both registers.
module oneshot_compare_timer import oct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [DIV_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CMD_BITS-1:0]     command_i,
  input  logic [CHAN_BITS-1:0]    channel_i,
  input  logic [COUNT_BITS-1:0]   delay_ticks_i,
  input  logic [MASK_BITS-1:0]    clear_mask_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [COUNT_BITS-1:0]   count_value_o,
  output logic [NUM_CHANNELS-1:0] armed_mask_o,
  output logic [MASK_BITS-1:0]    event_bits_o,
  output logic [WRAP_BITS-1:0]    wrap_count_o,
  output logic                    flow_stop_o,
  output logic                    wake_o
);

  logic [DIV_BITS-1:0] divide_q;
  logic                in_valid_q;
  oct_cmd_t            cmd_q;
  oct_state_t          state_q;
  oct_state_t          state_d;
  logic                wake_d;
  logic                out_valid_q;
  oct_state_t          res_q;
  logic                wake_q;
  logic                res_load;
  logic                in_load;

  assign cfg_ready_o = 1'b1;

  // The result register frees up in the same cycle its word is taken.
  assign res_load   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || res_load;
  assign in_load    = in_valid_i && in_ready_o;

  oct_step u_step (
    .state_i  (state_q),
    .cmd_i    (cmd_q),
    .divide_i (divide_q),
    .state_o  (state_d),
    .wake_o   (wake_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divide_q    <= DIVIDE_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        divide_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (res_load) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cmd_q <= '{command:     command_i,
                 channel:     channel_i,
                 delay_ticks: delay_ticks_i,
                 clear_mask:  clear_mask_i};
    end
    if (res_load) begin
      res_q  <= state_d;
      wake_q <= wake_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign count_value_o = res_q.counter;
  assign armed_mask_o  = res_q.armed;
  assign event_bits_o  = res_q.events;
  assign wrap_count_o  = res_q.wraps;
  assign flow_stop_o   = res_q.stop;
  assign wake_o        = wake_q;

endmodule

// ===== rtl/core/oct_checker.sv =====
// Port-level assertions for the one-shot compare timer, bound to the top level.
// Depends on oct_pkg for field widths and on oneshot_compare_timer for the bind.
module oct_checker import oct_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [COUNT_BITS-1:0] count_value_o,
  input logic [MASK_BITS-1:0]  event_bits_o,
  input logic                  wake_o
);

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_value_o) &&
      $stable(event_bits_o) && $stable(wake_o))
    else $error("result word changed while stalled");

  // A wake always leaves at least one event bit set in the same word.
  a_wake_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_o |-> event_bits_o != '0)
    else $error("wake without an event bit");

  // A wake that lands on zero came from a wrap, so the overflow event is set.
  a_wrap_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_o && count_value_o == '0 |-> event_bits_o[NUM_CHANNELS])
    else $error("wrap without overflow event");

  // The result side comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind oneshot_compare_timer oct_checker u_oct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .count_value_o (count_value_o),
  .event_bits_o  (event_bits_o),
  .wake_o        (wake_o)
);

// ===== sim/oneshot_compare_timer_tb.sv =====
// Self-checking testbench for oneshot_compare_timer: random and directed command words,
// checked against a cycle-free timer predictor kept in the bench.
// Depends on oct_pkg and on the RTL of the block only.
`timescale 1ns / 100ps

module oneshot_compare_timer_tb;
  import oct_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = CMD_BITS'(CMD_RESTART + 1);
  localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = '1;
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned REPORT_LIMIT  = 100;

  typedef enum logic {ACT_WORD, ACT_DIVIDE} stim_act_e;
  typedef enum logic [1:0] {PACE_FULL, PACE_SPARSE, PACE_BURSTY} pace_e;

  typedef struct packed {
    stim_act_e             act;
    logic [CMD_BITS-1:0]   command;
    logic [CHAN_BITS-1:0]  channel;
    logic [COUNT_BITS-1:0] delay_ticks;
    logic [MASK_BITS-1:0]  clear_mask;
    logic [DIV_BITS-1:0]   divide;
    logic [7:0]            gap;
  } stim_entry_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]   count_value;
    logic [NUM_CHANNELS-1:0] armed_mask;
    logic [MASK_BITS-1:0]    event_bits;
    logic [WRAP_BITS-1:0]    wrap_count;
    logic                    flow_stop;
    logic                    wake;
  } timer_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [DIV_BITS-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [CMD_BITS-1:0]     command_i = '0;
  logic [CHAN_BITS-1:0]    channel_i = '0;
  logic [COUNT_BITS-1:0]   delay_ticks_i = '0;
  logic [MASK_BITS-1:0]    clear_mask_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [COUNT_BITS-1:0]   count_value_o;
  logic [NUM_CHANNELS-1:0] armed_mask_o;
  logic [MASK_BITS-1:0]    event_bits_o;
  logic [WRAP_BITS-1:0]    wrap_count_o;
  logic                    flow_stop_o;
  logic                    wake_o;

  oneshot_compare_timer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .channel_i     (channel_i),
    .delay_ticks_i (delay_ticks_i),
    .clear_mask_i  (clear_mask_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .count_value_o (count_value_o),
    .armed_mask_o  (armed_mask_o),
    .event_bits_o  (event_bits_o),
    .wrap_count_o  (wrap_count_o),
    .flow_stop_o   (flow_stop_o),
    .wake_o        (wake_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Timer state as the bench expects it after every accepted word.
  logic [COUNT_BITS-1:0]    tmr_counter = '0;
  logic [PRESCALE_BITS-1:0] tmr_prescale = '0;
  logic [COUNT_BITS-1:0]    tmr_compare [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  tmr_armed = '0;
  logic [MASK_BITS-1:0]     tmr_events = '0;
  logic [WRAP_BITS-1:0]     tmr_wraps = '0;
  logic                     tmr_stop = 1'b0;
  logic [DIV_BITS-1:0]      tmr_divide = DIVIDE_RESET;

  stim_entry_t pending [$];
  timer_word_t expected_words [$];
  stim_entry_t in_cur = '0;
  stim_entry_t cfg_cur = '0;
  logic        in_busy = 1'b0;
  logic        cfg_busy = 1'b0;
  int unsigned gap_left = 0;
  int unsigned words_accepted = 0;
  int unsigned results_taken = 0;
  int unsigned taken_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;
  logic        rx_quiet = 1'b0;
  logic        hold_done = 1'b0;

  initial begin
    for (int k = 0; k < NUM_CHANNELS; k++) tmr_compare[k] = '0;
  end

  function automatic timer_word_t predict_timer_word(stim_entry_t it);
    timer_word_t w;
    int unsigned div;
    int unsigned idx;
    logic        hit;
    div = tmr_divide;
    if (div < DIVIDE_MIN) div = DIVIDE_MIN;
    if (div > DIVIDE_MAX) div = DIVIDE_MAX;
    hit = 1'b0;
    case (it.command)
      CMD_TICK: begin
        if (int'(tmr_prescale) + 1 >= div) begin
          tmr_prescale = '0;
          tmr_counter = tmr_counter + COUNT_BITS'(1);
          // The wrap is applied before the compare channels look at the new count.
          if (tmr_counter == '0) begin
            tmr_wraps = tmr_wraps + WRAP_BITS'(1);
            tmr_events[NUM_CHANNELS] = 1'b1;
            hit = 1'b1;
          end
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (tmr_armed[k] && tmr_compare[k] == tmr_counter) begin
              tmr_armed[k] = 1'b0;
              tmr_events[k] = 1'b1;
              if (k + 1 == STOP_CHANNEL) tmr_stop = 1'b1;
              hit = 1'b1;
            end
          end
        end else begin
          tmr_prescale = tmr_prescale + PRESCALE_BITS'(1);
        end
      end
      CMD_ARM: begin
        if (it.channel >= 1 && it.channel <= NUM_CHANNELS) begin
          idx = it.channel - 1;
          tmr_compare[idx] = tmr_counter + it.delay_ticks;
          tmr_armed[idx] = 1'b1;
        end
      end
      CMD_CLEAR:   tmr_events = tmr_events & ~it.clear_mask;
      CMD_RELEASE: tmr_stop = 1'b0;
      CMD_RESTART: begin
        tmr_counter = '0;
        tmr_prescale = '0;
        tmr_wraps = '0;
      end
      default: ;
    endcase
    w.count_value = tmr_counter;
    w.armed_mask  = tmr_armed;
    w.event_bits  = tmr_events;
    w.wrap_count  = tmr_wraps;
    w.flow_stop   = tmr_stop;
    w.wake        = hit;
    return w;
  endfunction

  function automatic logic [7:0] pick_gap(pace_e pace);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (pace)
      PACE_FULL:   return 8'd0;
      PACE_SPARSE: return (r == 0) ? 8'd1 : 8'd0;
      default: begin
        if (r < 70) return 8'd0;
        else if (r < 95) return 8'($urandom_range(1, 3));
        else return 8'($urandom_range(8, 40));
      end
    endcase
  endfunction

  task automatic add_word(logic [CMD_BITS-1:0] cmd, logic [CHAN_BITS-1:0] ch,
                          logic [COUNT_BITS-1:0] delay, logic [MASK_BITS-1:0] mask,
                          pace_e pace);
    stim_entry_t e;
    e = '0;
    e.act = ACT_WORD;
    e.command = cmd;
    e.channel = ch;
    e.delay_ticks = delay;
    e.clear_mask = mask;
    e.gap = pick_gap(pace);
    pending.push_back(e);
  endtask

  task automatic add_divide(logic [DIV_BITS-1:0] value);
    stim_entry_t e;
    e = '0;
    e.act = ACT_DIVIDE;
    e.divide = value;
    pending.push_back(e);
  endtask

  // Mostly ticks and arms with short delays, so that matches actually happen.
  task automatic add_random_word(pace_e pace);
    int unsigned           r;
    logic [CMD_BITS-1:0]   cmd;
    logic [CHAN_BITS-1:0]  ch;
    logic [COUNT_BITS-1:0] delay;
    r = $urandom_range(0, 99);
    ch = CHAN_BITS'($urandom_range(0, 3));
    delay = COUNT_BITS'($urandom);
    if (r < 55) cmd = CMD_TICK;
    else if (r < 75) begin
      cmd = CMD_ARM;
      if ($urandom_range(0, 9) != 0) ch = CHAN_BITS'($urandom_range(1, NUM_CHANNELS));
      r = $urandom_range(0, 99);
      if (r < 60) delay = COUNT_BITS'($urandom_range(1, 4));
      else if (r < 75) delay = '0;
    end
    else if (r < 85) cmd = CMD_CLEAR;
    else if (r < 91) cmd = CMD_RELEASE;
    else if (r < 95) cmd = CMD_RESTART;
    else cmd = CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    add_word(cmd, ch, delay, MASK_BITS'($urandom_range(0, 15)), pace);
  endtask

  // Driver: offers pending words and divide writes; writes wait for an empty pipeline.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(predict_timer_word(in_cur));
        words_accepted++;
        in_busy = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        tmr_divide = cfg_data_i;
        cfg_busy = 1'b0;
      end
      if (!in_busy && !cfg_busy) begin
        if (gap_left > 0) gap_left--;
        else if (pending.size() > 0) begin
          if (pending[0].act == ACT_WORD) begin
            in_cur = pending.pop_front();
            in_busy = 1'b1;
            gap_left = in_cur.gap;
          end else if (words_accepted == results_taken) begin
            cfg_cur = pending.pop_front();
            cfg_busy = 1'b1;
          end
        end
      end
      in_valid_i    <= in_busy;
      command_i     <= in_cur.command;
      channel_i     <= in_cur.channel;
      delay_ticks_i <= in_cur.delay_ticks;
      clear_mask_i  <= in_cur.clear_mask;
      cfg_valid_i   <= cfg_busy;
      cfg_data_i    <= cfg_cur.divide;
    end
  end

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Monitor: takes result words, checks them, and paces out_ready_i.
  always @(posedge clk_i) begin
    timer_word_t want;
    logic        rdy;
    int unsigned roll;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("result word with nothing expected: count_value %0d", count_value_o);
        end else begin
          want = expected_words.pop_front();
          check_field("count_value", 16'(want.count_value), 16'(count_value_o));
          check_field("armed_mask", 16'(want.armed_mask), 16'(armed_mask_o));
          check_field("event_bits", 16'(want.event_bits), 16'(event_bits_o));
          check_field("wrap_count", 16'(want.wrap_count), 16'(wrap_count_o));
          check_field("flow_stop", 16'(want.flow_stop), 16'(flow_stop_o));
          check_field("wake", 16'(want.wake), 16'(wake_o));
        end
        taken_cnt++;
      end
      // One long hold-off lets the input side fill up and stall.
      if (!hold_done && taken_cnt >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!rx_quiet) begin
          roll = $urandom_range(0, 99);
          if (roll < 12) stall_left = $urandom_range(1, 3);
          else if (roll < 14) stall_left = $urandom_range(10, 40);
        end
      end
      if (quiet_left > 0) quiet_left--;
      else begin
        quiet_left = 200;
        rx_quiet = ($urandom_range(0, 2) == 0);
      end
      out_ready_i   <= rdy;
      results_taken <= taken_cnt;
    end
  end

  initial begin
    logic [DIV_BITS-1:0] divides [10];
    divides = '{7'd1, 7'd2, 7'd0, 7'd5, 7'd127, 7'd64, 7'd65, 7'd3, 7'd0, 7'd1};
    divides[8] = DIV_BITS'($urandom_range(0, 127));

    // Directed words, starting at the reset divide of 64.
    add_word(CMD_TICK, '0, '0, '0, PACE_BURSTY);
    add_word(CMD_TICK, '1, '1, '1, PACE_BURSTY);
    add_word(CMD_ARM, 2'd1, 16'd0, '0, PACE_BURSTY);
    add_word(CMD_ARM, 2'd2, 16'hFFFF, '1, PACE_BURSTY);
    add_word(CMD_ARM, 2'd3, 16'd1, '0, PACE_BURSTY);
    add_word(CMD_ARM, 2'd0, 16'd5, '1, PACE_BURSTY);
    add_word(CMD_CLEAR, '0, '0, '0, PACE_BURSTY);
    add_word(CMD_CLEAR, '1, '1, '1, PACE_BURSTY);
    add_word(CMD_RELEASE, '1, '1, '1, PACE_BURSTY);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      add_word(c[CMD_BITS-1:0], '1, '1, '1, PACE_BURSTY);
    repeat (8) add_word(CMD_TICK, '0, '0, '0, PACE_FULL);
    // Lower the divide below the prescaler count: the next tick must advance.
    add_divide(7'd3);
    add_word(CMD_TICK, '0, '0, '0, PACE_BURSTY);
    add_word(CMD_ARM, 2'd1, 16'd2, '0, PACE_BURSTY);
    repeat (6) add_word(CMD_TICK, '0, '0, '0, PACE_FULL);
    add_word(CMD_RELEASE, '0, '0, '0, PACE_BURSTY);
    add_word(CMD_RESTART, '0, '0, '0, PACE_BURSTY);
    add_word(CMD_CLEAR, '0, '0, '1, PACE_BURSTY);

    // Random phases, each under its own divide.
    foreach (divides[p]) begin
      add_divide(divides[p]);
      repeat (52) add_random_word((p % 3 == 1) ? PACE_FULL : PACE_BURSTY);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (pending.size() != 0 || in_busy || cfg_busy || words_accepted != taken_cnt)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
